[hdl/sprite_animation_sequencer_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sprite animation sequencer
// Clocked property checks; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef SPRITE_ANIMATION_SEQUENCER_MACROS_SVH
`define SPRITE_ANIMATION_SEQUENCER_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked only outside reset
`define SAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define SAS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SAS_ASSERT(lbl, prop, msg)
`define SAS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[hdl/sas_pkg.sv]
// ----------------------------------------------------------------------------
// sas_pkg
// Shared types and constants of the sprite animation sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sas_pkg;

  localparam int MAX_FRAMES  = 64;
  localparam int MAX_CHAIN   = 32;
  localparam int RESULT_CAP  = 32;
  localparam int CHAIN_LIMIT = (MAX_CHAIN < RESULT_CAP) ? MAX_CHAIN : RESULT_CAP;

  localparam int IDX_W  = $clog2(MAX_FRAMES);
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int STEP_W = $clog2(CHAIN_LIMIT + 1);
  localparam int TICK_W = 24;
  localparam int HND_W  = 16;
  localparam int MUL_W  = 8;

  // config register indexes
  localparam logic CFG_SPEED  = 1'b0;
  localparam logic CFG_ATTACH = 1'b1;

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_APPEND  = 3'd1,
    ACT_RESTART = 3'd2,
    ACT_SETFRZ  = 3'd3,
    ACT_CLEAR   = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    K_SPRITE    = 3'd0,
    K_DESTROY   = 3'd1,
    K_SOUND     = 3'd2,
    K_EFFECT    = 3'd3,
    K_EXPLOSION = 3'd4,
    K_JUMP      = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_DESTROY   = 3'd1,
    EV_SOUND     = 3'd2,
    EV_EFFECT    = 3'd3,
    EV_EXPLOSION = 3'd4,
    EV_REJECT    = 3'd5
  } event_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SHOW_RD,
    S_SHOW_OUT,
    S_JCHK_RD,
    S_JCHK,
    S_ADV_RD,
    S_ADV,
    S_CH_RD,
    S_CH_EV,
    S_CH_NRD,
    S_CH_OUT
  } state_t;

  // one table entry, 58 bits
  typedef struct packed {
    logic [2:0]       kind;
    logic [HND_W-1:0] duration;
    logic             freeze;
    logic [HND_W-1:0] sprite;
    logic [HND_W-1:0] data;
    logic [5:0]       next;
  } frame_entry_t;

  typedef struct packed {
    logic [2:0]       action;
    logic [2:0]       kind;
    logic [HND_W-1:0] duration;
    logic             freeze;
    logic [5:0]       jump_target;
    logic [HND_W-1:0] sprite_handle;
    logic [HND_W-1:0] data_handle;
    logic             freeze_value;
  } item_t;

  typedef struct packed {
    logic [2:0]       event_kind;
    logic [HND_W-1:0] event_data;
    logic             looped;
    logic [5:0]       frame_index;
    logic [HND_W-1:0] shown_sprite;
    logic             last;
  } result_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    frame_entry_t     wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [MUL_W-1:0] speed;
    logic             attached;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] frame_count;
    logic [IDX_W-1:0] cur_frame;
  } status_t;

endpackage

[hdl/sas_frame_mem.sv]
// ----------------------------------------------------------------------------
// sas_frame_mem
// Frame table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sas_frame_mem (
  input  logic                  clk,
  input  sas_pkg::mem_req_t     req,
  output sas_pkg::frame_entry_t rd_data
);

  sas_pkg::frame_entry_t table_r [sas_pkg::MAX_FRAMES];
  sas_pkg::frame_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      table_r[req.wr_addr] <= req.wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= table_r[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/sas_out_reg.sv]
// ----------------------------------------------------------------------------
// sas_out_reg
// Result holding register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sas_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sas_pkg::result_t  res,
  input  logic              out_ready,
  output logic              out_valid,
  output sas_pkg::result_t  out_res
);

  logic             valid_r;
  sas_pkg::result_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

[hdl/sas_seq.sv]
// ----------------------------------------------------------------------------
// sas_seq
// Sequencer: item decode, frame table read-modify-write, action chain walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sas_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sas_pkg::item_t        in_item,
  input  sas_pkg::cfg_t         cfg,
  output sas_pkg::mem_req_t     mem_req,
  input  sas_pkg::frame_entry_t rd_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  output logic                  push,
  output sas_pkg::result_t      res,
  output sas_pkg::status_t      status
);

  localparam int CNT_W  = sas_pkg::CNT_W;
  localparam int IDX_W  = sas_pkg::IDX_W;
  localparam int STEP_W = sas_pkg::STEP_W;
  localparam int TICK_W = sas_pkg::TICK_W;

  sas_pkg::state_t  state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt;
  logic             frozen_r, frozen_nxt;
  logic             js_r, js_nxt;
  sas_pkg::event_t  ev_r, ev_nxt;
  logic [sas_pkg::HND_W-1:0] data_r, data_nxt;
  logic             more_r, more_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  sas_pkg::item_t   item_r, item_nxt;

  logic             tick_chain;
  logic             expired;
  logic             app_bad;
  logic             app_jmp;
  logic [CNT_W-1:0] cur_inc;
  logic [CNT_W-1:0] link;
  logic [IDX_W-1:0] adv_idx;
  logic             room;
  logic             fin;

  function automatic sas_pkg::frame_entry_t make_entry(input sas_pkg::item_t it);
    sas_pkg::frame_entry_t e;
    e      = '0;
    e.kind = it.kind;
    if (it.kind == sas_pkg::K_SPRITE) begin
      e.duration = it.duration;
      e.freeze   = it.freeze;
      e.sprite   = it.sprite_handle;
    end
    if (it.kind == sas_pkg::K_SOUND || it.kind == sas_pkg::K_EFFECT) begin
      e.data = it.data_handle;
    end
    if (it.kind == sas_pkg::K_JUMP) begin
      e.next = it.jump_target;
    end
    return e;
  endfunction

  // decode of the offered item and the link of the entry just read
  always_comb begin
    expired    = (ticks_r <= TICK_W'(1));
    tick_chain = (count_r > CNT_W'(1)) && !frozen_r && (expired || js_r);
    app_bad    = (count_r >= CNT_W'(sas_pkg::MAX_FRAMES)) ||
                 (in_item.kind > sas_pkg::K_JUMP) ||
                 ((in_item.kind == sas_pkg::K_JUMP) &&
                  ({1'b0, in_item.jump_target} >= count_r));
    app_jmp    = !app_bad && (in_item.kind == sas_pkg::K_JUMP);
    // non-jump frames link to the following frame, the last one to frame 0
    cur_inc    = {1'b0, cur_r} + CNT_W'(1);
    if (rd_data.kind == sas_pkg::K_JUMP) begin
      link = {1'b0, rd_data.next};
    end else if (cur_inc < count_r) begin
      link = cur_inc;
    end else begin
      link = '0;
    end
    adv_idx = (link < count_r) ? link[IDX_W-1:0] : cur_r;
    room    = !out_valid || out_ready;
    fin     = !more_r || (steps_r == STEP_W'(sas_pkg::CHAIN_LIMIT - 1));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sas_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_item.action == sas_pkg::ACT_TICK && tick_chain) begin
            state_nxt = js_r ? sas_pkg::S_CH_RD : sas_pkg::S_ADV_RD;
          end else if (in_item.action == sas_pkg::ACT_APPEND && app_jmp) begin
            state_nxt = sas_pkg::S_JCHK_RD;
          end else begin
            state_nxt = sas_pkg::S_SHOW_RD;
          end
        end
      end
      sas_pkg::S_SHOW_RD:  state_nxt = sas_pkg::S_SHOW_OUT;
      sas_pkg::S_SHOW_OUT: begin
        if (room) begin
          state_nxt = sas_pkg::S_IDLE;
        end
      end
      sas_pkg::S_JCHK_RD:  state_nxt = sas_pkg::S_JCHK;
      sas_pkg::S_JCHK:     state_nxt = sas_pkg::S_SHOW_RD;
      sas_pkg::S_ADV_RD:   state_nxt = sas_pkg::S_ADV;
      sas_pkg::S_ADV:      state_nxt = sas_pkg::S_CH_RD;
      sas_pkg::S_CH_RD:    state_nxt = sas_pkg::S_CH_EV;
      sas_pkg::S_CH_EV:    state_nxt = sas_pkg::S_CH_NRD;
      sas_pkg::S_CH_NRD:   state_nxt = sas_pkg::S_CH_OUT;
      sas_pkg::S_CH_OUT: begin
        if (room) begin
          state_nxt = fin ? sas_pkg::S_IDLE : sas_pkg::S_CH_EV;
        end
      end
      default:             state_nxt = sas_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    count_nxt  = count_r;
    cur_nxt    = cur_r;
    ticks_nxt  = ticks_r;
    frozen_nxt = frozen_r;
    js_nxt     = js_r;
    ev_nxt     = ev_r;
    data_nxt   = data_r;
    more_nxt   = more_r;
    steps_nxt  = steps_r;
    item_nxt   = item_r;
    mem_req    = '0;
    push       = 1'b0;
    res        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      sas_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt  = in_item;
          ev_nxt    = sas_pkg::EV_NONE;
          data_nxt  = '0;
          steps_nxt = '0;
          unique case (in_item.action)
            sas_pkg::ACT_TICK: begin
              if ((count_r > CNT_W'(1)) && !frozen_r) begin
                ticks_nxt = expired ? '0 : ticks_r - TICK_W'(1);
                if (tick_chain) begin
                  js_nxt = 1'b0;
                end
              end
            end
            sas_pkg::ACT_APPEND: begin
              if (app_bad) begin
                ev_nxt = sas_pkg::EV_REJECT;
              end else if (!app_jmp) begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = count_r[IDX_W-1:0];
                mem_req.wr_data = make_entry(in_item);
                count_nxt       = count_r + CNT_W'(1);
                if (count_r == '0) begin
                  cur_nxt = '0;
                end
              end
            end
            sas_pkg::ACT_RESTART: begin
              frozen_nxt = 1'b0;
              js_nxt     = 1'b1;
              cur_nxt    = '0;
            end
            sas_pkg::ACT_SETFRZ: begin
              frozen_nxt = in_item.freeze_value;
              if (!in_item.freeze_value) begin
                js_nxt = 1'b0;
              end
            end
            sas_pkg::ACT_CLEAR: begin
              count_nxt  = '0;
              cur_nxt    = '0;
              ticks_nxt  = '0;
              frozen_nxt = 1'b0;
              js_nxt     = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      sas_pkg::S_SHOW_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = cur_r;
      end
      sas_pkg::S_SHOW_OUT: begin
        push             = room;
        res.event_kind   = ev_r;
        res.frame_index  = cur_r;
        res.shown_sprite = (count_r == '0) ? '0 : rd_data.sprite;
        res.last         = 1'b1;
      end
      sas_pkg::S_JCHK_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = item_r.jump_target;
      end
      sas_pkg::S_JCHK: begin
        // target must not itself be a jump frame
        if (rd_data.kind == sas_pkg::K_JUMP) begin
          ev_nxt = sas_pkg::EV_REJECT;
        end else begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = count_r[IDX_W-1:0];
          mem_req.wr_data = make_entry(item_r);
          count_nxt       = count_r + CNT_W'(1);
        end
      end
      sas_pkg::S_ADV_RD, sas_pkg::S_CH_RD, sas_pkg::S_CH_NRD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = cur_r;
      end
      sas_pkg::S_ADV: begin
        cur_nxt = adv_idx;
      end
      sas_pkg::S_CH_EV: begin
        data_nxt = '0;
        case (rd_data.kind)
          sas_pkg::K_DESTROY: begin
            ev_nxt   = cfg.attached ? sas_pkg::EV_DESTROY : sas_pkg::EV_NONE;
            more_nxt = 1'b0;
          end
          sas_pkg::K_SOUND: begin
            ev_nxt   = sas_pkg::EV_SOUND;
            data_nxt = rd_data.data;
            more_nxt = 1'b1;
          end
          sas_pkg::K_EFFECT: begin
            ev_nxt   = sas_pkg::EV_EFFECT;
            data_nxt = rd_data.data;
            more_nxt = 1'b1;
          end
          sas_pkg::K_EXPLOSION: begin
            ev_nxt   = sas_pkg::EV_EXPLOSION;
            more_nxt = 1'b1;
          end
          sas_pkg::K_JUMP: begin
            ev_nxt   = sas_pkg::EV_NONE;
            more_nxt = 1'b1;
          end
          default: begin
            ev_nxt   = sas_pkg::EV_NONE;
            more_nxt = 1'b0;
          end
        endcase
        if (more_nxt) begin
          cur_nxt = adv_idx;
        end
      end
      sas_pkg::S_CH_OUT: begin
        // rd_data holds the entry of the current frame here
        push             = room;
        res.event_kind   = ev_r;
        res.event_data   = data_r;
        res.looped       = (cur_r == '0) && cfg.attached;
        res.frame_index  = cur_r;
        res.shown_sprite = rd_data.sprite;
        res.last         = fin;
        if (room) begin
          steps_nxt = steps_r + STEP_W'(1);
          if (fin) begin
            ticks_nxt = {8'd0, rd_data.duration} * {16'd0, cfg.speed};
            if (rd_data.freeze) begin
              ticks_nxt  = '0;
              frozen_nxt = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sas_pkg::S_IDLE;
      count_r  <= '0;
      cur_r    <= '0;
      ticks_r  <= '0;
      frozen_r <= 1'b0;
      js_r     <= 1'b1;
      more_r   <= 1'b0;
      steps_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      cur_r    <= cur_nxt;
      ticks_r  <= ticks_nxt;
      frozen_r <= frozen_nxt;
      js_r     <= js_nxt;
      more_r   <= more_nxt;
      steps_r  <= steps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_r   <= ev_nxt;
    data_r <= data_nxt;
    item_r <= item_nxt;
  end

  assign status.frame_count = count_r;
  assign status.cur_frame   = cur_r;

endmodule

[hdl/sprite_animation_sequencer.sv]
// A single-result item reads the current frame, then pushes its result; a jump append
//   first reads and checks its target. A chain tick, advancing first unless a start is
//   pending, reads and pushes one result per step. One item at a time, paced by the
//   registered table read; a waiting result that is not taken stalls the walk.
// Reset (rst_n, synchronous, active low): empty table, frame 0, not frozen,
//   start pending, speed multiplier 1, object attached; table contents kept.
// ----------------------------------------------------------------------------
// sprite_animation_sequencer
// Animation frame table with tick countdown and an action chain walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sprite_animation_sequencer_macros.svh"

module sprite_animation_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  // frame_kind[2:0], frame_duration[18:3], frame_freeze[19], jump_target[25:20],
  // sprite_handle[41:26], data_handle[57:42], freeze_value[58], zero fill
  input  logic [63:0] in_tdata,
  // action[2:0]
  input  logic [2:0]  in_tuser,
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  // event_data[15:0], looped[16], frame_index[22:17], shown_sprite[38:23],
  // zero fill
  output logic [39:0] out_tdata,
  // event_kind[2:0]
  output logic [2:0]  out_tuser,
  output logic        out_tlast,
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  sas_pkg::item_t        item;
  sas_pkg::cfg_t         cfg_r;
  sas_pkg::mem_req_t     mem_req;
  sas_pkg::frame_entry_t rd_data;
  sas_pkg::result_t      res;
  sas_pkg::result_t      out_res;
  sas_pkg::status_t      status;
  logic                  push;

  // unpack the input item
  assign item.action        = in_tuser;
  assign item.kind          = in_tdata[2:0];
  assign item.duration      = in_tdata[18:3];
  assign item.freeze        = in_tdata[19];
  assign item.jump_target   = in_tdata[25:20];
  assign item.sprite_handle = in_tdata[41:26];
  assign item.data_handle   = in_tdata[57:42];
  assign item.freeze_value  = in_tdata[58];

  // Config registers. A speed of zero is stored as one so the sprite time
  // product never collapses to zero by mistake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed    <= 8'd1;
      cfg_r.attached <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == sas_pkg::CFG_SPEED) begin
        cfg_r.speed <= (cfg_wdata == 8'd0) ? 8'd1 : cfg_wdata;
      end else begin
        cfg_r.attached <= cfg_wdata[0];
      end
    end
  end

  // Frame table. Entries beyond the frame count are never used, so the
  // table needs no clearing after reset or after a clear-table item.
  sas_frame_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Sequencer: decodes an item, reads the current frame (or a jump target),
  // and walks the chain one table read per step. Every result carries the
  // sprite of the frame current after it, which the same read provides.
  sas_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (item),
    .cfg       (cfg_r),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .push      (push),
    .res       (res),
    .status    (status)
  );

  // Result register: the sequencer takes the next item while the last
  // result of the previous one still waits here.
  sas_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res       (res),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_res   (out_res)
  );

  assign out_tuser = out_res.event_kind;
  assign out_tlast = out_res.last;
  assign out_tdata = {1'b0, out_res.shown_sprite, out_res.frame_index,
                      out_res.looped, out_res.event_data};

  // a new result never overwrites one that has not been taken
  `SAS_ASSERT(a_push_room, push |-> (!out_tvalid || out_tready), "result overwritten")
  // a rejected append is always the single, final result of its item
  `SAS_ASSERT(a_reject_last, (out_tvalid && out_tuser == sas_pkg::EV_REJECT) |-> out_tlast, "reject not last")
  // the frame count never passes the table depth
  `SAS_ASSERT(a_count_bound, status.frame_count <= sas_pkg::CNT_W'(sas_pkg::MAX_FRAMES), "frame count overflow")
  // the current frame names a written entry whenever the table is not empty
  `SAS_ASSERT(a_cur_valid, (status.frame_count == '0) || ({1'b0, status.cur_frame} < status.frame_count), "current frame out of range")
  // the result register is empty after reset
  `SAS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

[verif/sprite_animation_sequencer_checker.sv]
// ----------------------------------------------------------------------------
// sprite_animation_sequencer_checker
// Watches the item, result and config ports, predicts every result item of
// the sequencer and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprite_animation_sequencer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  output int unsigned pending,
  output int unsigned fail_count
);

  localparam int IDX_W = sas_pkg::IDX_W;
  localparam int HND_W = sas_pkg::HND_W;

  sas_pkg::frame_entry_t             frames [sas_pkg::MAX_FRAMES];
  logic [sas_pkg::CNT_W-1:0]         n_frames;
  logic [IDX_W-1:0]                  cur;
  logic [sas_pkg::TICK_W-1:0]        ticks_left;
  logic                              frozen;
  logic                              start_pending;
  logic [sas_pkg::MUL_W-1:0]         speed;
  logic                              attached;
  sas_pkg::result_t                  expected_q [$];

  function automatic logic [HND_W-1:0] shown_sprite();
    return (n_frames == 0) ? '0 : frames[cur].sprite;
  endfunction

  function automatic void expect_result(sas_pkg::event_t ev, logic [HND_W-1:0] data,
                                        logic lp);
    sas_pkg::result_t r;
    r.event_kind   = ev;
    r.event_data   = data;
    r.looped       = lp;
    r.frame_index  = cur;
    r.shown_sprite = shown_sprite();
    r.last         = 1'b0;
    expected_q.insert(expected_q.size(), r);
  endfunction

  // follow the link of the current frame, if it points inside the table
  function automatic void follow_link();
    logic [IDX_W-1:0] nx;
    nx = frames[cur].next;
    if (nx < n_frames) cur = nx;
  endfunction

  function automatic int walk_chain();
    int                    n;
    bit                    more;
    sas_pkg::event_t       ev;
    logic [HND_W-1:0]      d;
    sas_pkg::frame_entry_t e;
    n    = 0;
    more = 1'b1;
    while (more && n < sas_pkg::CHAIN_LIMIT) begin
      e  = frames[cur];
      ev = sas_pkg::EV_NONE;
      d  = '0;
      case (e.kind)
        sas_pkg::K_DESTROY: begin
          if (attached) ev = sas_pkg::EV_DESTROY;
          more = 1'b0;
        end
        sas_pkg::K_SOUND: begin
          ev = sas_pkg::EV_SOUND;
          d  = e.data;
        end
        sas_pkg::K_EFFECT: begin
          ev = sas_pkg::EV_EFFECT;
          d  = e.data;
        end
        sas_pkg::K_EXPLOSION: ev = sas_pkg::EV_EXPLOSION;
        sas_pkg::K_JUMP: ;
        default: more = 1'b0;
      endcase
      if (more) follow_link();
      expect_result(ev, d, (cur == 0) && attached);
      n++;
    end
    return n;
  endfunction

  function automatic int tick_frame();
    logic expired;
    int   n;
    if (n_frames <= 1 || frozen) return 0;
    expired    = (ticks_left <= 1);
    ticks_left = expired ? '0 : ticks_left - 1'b1;
    if (!expired && !start_pending) return 0;
    if (!start_pending) follow_link();
    start_pending = 1'b0;
    n = walk_chain();
    ticks_left = frames[cur].duration * speed;
    if (frames[cur].freeze) begin
      ticks_left = '0;
      frozen     = 1'b1;
    end
    return n;
  endfunction

  function automatic logic store_frame(logic [63:0] d);
    sas_pkg::frame_entry_t e;
    logic [2:0]            k;
    logic [5:0]            tgt;
    k   = d[2:0];
    tgt = d[25:20];
    if (n_frames >= sas_pkg::MAX_FRAMES || k > sas_pkg::K_JUMP) return 1'b0;
    if (k == sas_pkg::K_JUMP && (tgt >= n_frames || frames[tgt].kind == sas_pkg::K_JUMP))
      return 1'b0;
    e      = '0;
    e.kind = k;
    if (k == sas_pkg::K_SPRITE) begin
      e.duration = d[18:3];
      e.freeze   = d[19];
      e.sprite   = d[41:26];
    end
    if (k == sas_pkg::K_SOUND || k == sas_pkg::K_EFFECT) e.data = d[57:42];
    e.next = (k == sas_pkg::K_JUMP) ? tgt : '0;
    if (n_frames == 0)
      cur = '0;
    else if (frames[n_frames[IDX_W-1:0] - 1'b1].kind != sas_pkg::K_JUMP)
      frames[n_frames[IDX_W-1:0] - 1'b1].next = n_frames[IDX_W-1:0];
    frames[n_frames[IDX_W-1:0]] = e;
    n_frames++;
    return 1'b1;
  endfunction

  function automatic void predict_item(logic [2:0] act, logic [63:0] d);
    int              n;
    sas_pkg::event_t ev;
    n  = 0;
    ev = sas_pkg::EV_NONE;
    case (act)
      sas_pkg::ACT_TICK:   n = tick_frame();
      sas_pkg::ACT_APPEND: if (!store_frame(d)) ev = sas_pkg::EV_REJECT;
      sas_pkg::ACT_RESTART: begin
        frozen        = 1'b0;
        start_pending = 1'b1;
        cur           = '0;
      end
      sas_pkg::ACT_SETFRZ: begin
        frozen = d[58];
        if (!d[58]) start_pending = 1'b0;
      end
      sas_pkg::ACT_CLEAR: begin
        n_frames      = '0;
        cur           = '0;
        ticks_left    = '0;
        frozen        = 1'b0;
        start_pending = 1'b1;
      end
      default: ;
    endcase
    if (n == 0) expect_result(ev, '0, 1'b0);
    expected_q[expected_q.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string tag, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, tag, want, got);
    end
  endfunction

  always @(posedge clk) begin
    sas_pkg::result_t got;
    sas_pkg::result_t want;
    if (!rst_n) begin
      foreach (frames[i]) frames[i] = '0;
      n_frames      = '0;
      cur           = '0;
      ticks_left    = '0;
      frozen        = 1'b0;
      start_pending = 1'b1;
      speed         = 8'd1;
      attached      = 1'b1;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == sas_pkg::CFG_SPEED)
          speed = (cfg_wdata == 0) ? 8'd1 : cfg_wdata;
        else
          attached = cfg_wdata[0];
      end
      if (out_tvalid && out_tready) begin
        got.event_kind   = out_tuser;
        got.event_data   = out_tdata[15:0];
        got.looped       = out_tdata[16];
        got.frame_index  = out_tdata[22:17];
        got.shown_sprite = out_tdata[38:23];
        got.last         = out_tlast;
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: result item with nothing expected, expected none, actual %0h",
                   $time, got);
        end else begin
          want = expected_q.pop_front();
          check_field("event_kind", 16'(want.event_kind), 16'(got.event_kind));
          check_field("event_data", want.event_data, got.event_data);
          check_field("looped", 16'(want.looped), 16'(got.looped));
          check_field("frame_index", 16'(want.frame_index), 16'(got.frame_index));
          check_field("shown_sprite", want.shown_sprite, got.shown_sprite);
          check_field("last", 16'(want.last), 16'(got.last));
        end
      end
      if (in_tvalid && in_tready) predict_item(in_tuser, in_tdata);
    end
    pending <= expected_q.size();
  end

endmodule

[verif/sprite_animation_sequencer_tb.sv]
// ----------------------------------------------------------------------------
// sprite_animation_sequencer_tb
// Drives frame appends, ticks, restarts, freezes and table clears into the
// sequencer under several speed and attach settings, with random gaps on
// both stream sides and one long result stall. The checker next to the DUT
// predicts and compares every result item; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprite_animation_sequencer_tb;

  // worst case is far below this: 32 results per item, each behind the longest random stall
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int          PHASE_ITEMS = 12;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = 1'b0;
  logic [7:0]  cfg_wdata  = '0;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned cycle_count = 0;
  int unsigned sink_seen   = 0;
  int unsigned sent_items  = 0;

  // stimulus side view of the table, used to aim jump targets and to fill the table
  int          tab_len     = 0;
  bit          tab_jump [sas_pkg::MAX_FRAMES];
  int          speed_now   = 1;
  bit          full_rate   = 1'b0;   // no gaps on either side while set

  sprite_animation_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  sprite_animation_sequencer_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sprite_animation_sequencer_tb failed");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sink_seen <= sink_seen + 1;

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // random payload for items whose fields are don't-care; fill bits stay zero
  function automatic logic [63:0] noise();
    logic [63:0] v;
    v          = {$urandom(), $urandom()};
    v[63:59]   = '0;
    return v;
  endfunction

  // small durations so ticks reach expiry; a few full-range ones for bit coverage
  function automatic logic [15:0] pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'($urandom());
    if (speed_now > 8) return (r < 85) ? 16'd0 : 16'd1;
    return 16'($urandom_range(0, 3));
  endfunction

  // called on a rising edge; returns on the edge that accepted the item
  // (or after the gap that follows it)
  task automatic send_item(logic [2:0] act, logic [63:0] data);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    if (act <= sas_pkg::ACT_CLEAR) sent_items++;
    gap = full_rate ? 0 : idle_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic append_frame(logic [2:0] k, logic [15:0] dur, logic fz, logic [5:0] tgt,
                              logic [15:0] spr, logic [15:0] dat);
    logic fv;
    fv = $urandom_range(0, 1);
    send_item(sas_pkg::ACT_APPEND, {5'b0, fv, dat, spr, tgt, fz, dur, k});
    // mirror the accept rule so later jumps can aim at real frames
    if (tab_len < sas_pkg::MAX_FRAMES && k <= sas_pkg::K_JUMP &&
        (k != sas_pkg::K_JUMP || (tgt < tab_len && !tab_jump[tgt]))) begin
      tab_jump[tab_len] = (k == sas_pkg::K_JUMP);
      tab_len++;
    end
  endtask

  task automatic add_random_frame();
    int         r;
    logic [2:0] k;
    logic [5:0] tgt;
    r = $urandom_range(0, 99);
    if (r < 35)      k = sas_pkg::K_SPRITE;
    else if (r < 45) k = sas_pkg::K_DESTROY;
    else if (r < 60) k = sas_pkg::K_SOUND;
    else if (r < 72) k = sas_pkg::K_EFFECT;
    else if (r < 80) k = sas_pkg::K_EXPLOSION;
    else if (r < 95) k = sas_pkg::K_JUMP;
    else             k = 3'(sas_pkg::K_JUMP + $urandom_range(1, 2));   // undefined kinds
    if ($urandom_range(0, 99) < 85 && tab_len > 0)
      tgt = 6'($urandom_range(0, tab_len - 1));
    else
      tgt = 6'($urandom_range(0, 63));
    append_frame(k, pick_duration(), ($urandom_range(0, 9) == 0), tgt,
                 16'($urandom()), 16'($urandom()));
  endtask

  task automatic clear_table();
    send_item(sas_pkg::ACT_CLEAR, noise());
    tab_len = 0;
  endtask

  // both registers, on consecutive edges, while the block is idle
  task automatic set_config(logic [7:0] spd, logic att);
    cfg_we    <= 1'b1;
    cfg_index <= sas_pkg::CFG_SPEED;
    cfg_wdata <= spd;
    @(posedge clk);
    cfg_index <= sas_pkg::CFG_ATTACH;
    cfg_wdata <= {7'b0, att};
    @(posedge clk);
    cfg_we    <= 1'b0;
    speed_now = (spd == 0) ? 1 : spd;
  endtask

  // wait until every predicted result item has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Result sink: random ready pattern, plus one long hold-off once traffic is
  // flowing so the block backs up and stalls its input side.
  initial begin : result_sink
    bit held;
    int gap;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && sink_seen >= 60) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (full_rate) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        gap = idle_len();
        if (gap != 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned start;
    int          r;
    int          steps;
    logic [7:0]  spd;
    logic        att;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    set_config(8'd1, 1'b1);

    // ---- directed part -------------------------------------------------
    send_item(sas_pkg::ACT_TICK, noise());                          // empty table
    append_frame(sas_pkg::K_SPRITE, 16'd0, 1'b0, 6'd0, 16'hFFFF, 16'hFFFF);  // frame 0
    send_item(sas_pkg::ACT_TICK, noise());                          // one frame: idle
    append_frame(sas_pkg::K_JUMP, 16'd0, 1'b0, 6'd63, 16'd0, 16'd0);  // target out of range
    append_frame(sas_pkg::K_SOUND, 16'hFFFF, 1'b1, 6'd0, 16'hFFFF, 16'hFFFF); // frame 1
    append_frame(sas_pkg::K_EFFECT, 16'd0, 1'b0, 6'd0, 16'd0, 16'h0001);     // frame 2
    append_frame(sas_pkg::K_EXPLOSION, 16'd0, 1'b0, 6'd0, 16'd0, 16'h8000);  // frame 3
    append_frame(sas_pkg::K_DESTROY, 16'd0, 1'b0, 6'd0, 16'd0, 16'h1234);    // frame 4
    append_frame(sas_pkg::K_JUMP, 16'd0, 1'b0, 6'd0, 16'd0, 16'd0);   // frame 5, to 0
    append_frame(sas_pkg::K_JUMP, 16'd0, 1'b0, 6'd5, 16'd0, 16'd0);   // target is a jump
    append_frame(3'(sas_pkg::K_JUMP + 1), 16'd0, 1'b0, 6'd0, 16'd0, 16'd0);  // bad kind
    append_frame(3'(sas_pkg::K_JUMP + 2), 16'd0, 1'b0, 6'd0, 16'd0, 16'd0);  // bad kind
    // appended after the jump: the jump keeps pointing at frame 0
    append_frame(sas_pkg::K_SPRITE, 16'hFFFF, 1'b1, 6'd0, 16'h0000, 16'd0);  // frame 6
    send_item(sas_pkg::ACT_TICK, noise());     // start pending: show frame 0
    send_item(sas_pkg::ACT_TICK, noise());     // sound, effect, explosion, destroy
    send_item(sas_pkg::ACT_SETFRZ, 64'(1) << 58);
    send_item(sas_pkg::ACT_TICK, noise());     // frozen: idle
    send_item(sas_pkg::ACT_SETFRZ, 64'(0));
    send_item(sas_pkg::ACT_TICK, noise());     // jump back to frame 0, looped
    send_item(sas_pkg::ACT_RESTART, noise());
    send_item(sas_pkg::ACT_TICK, noise());
    send_item(3'(sas_pkg::ACT_CLEAR + 1), noise());     // unknown actions
    send_item(3'(sas_pkg::ACT_CLEAR + 2), noise());
    send_item(3'(sas_pkg::ACT_CLEAR + 3), noise());
    clear_table();
    send_item(sas_pkg::ACT_TICK, noise());
    drain();

    // ---- random part, one config setting per phase ---------------------
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       begin spd = 8'd1;   att = 1'b1; end
        1:       begin spd = 8'd0;   att = 1'b0; end   // zero is stored as 1
        2:       begin spd = 8'd255; att = 1'b1; end
        3:       begin spd = 8'($urandom_range(2, 8)); att = 1'b1; end
        4:       begin spd = 8'($urandom_range(1, 255)); att = 1'($urandom_range(0, 1)); end
        default: begin spd = 8'd3;   att = 1'b0; end
      endcase
      set_config(spd, att);
      full_rate = (ph == 3);

      if (ph == 1) begin
        // fill the table to the top, try two more, then walk it
        clear_table();
        while (tab_len < sas_pkg::MAX_FRAMES) add_random_frame();
        add_random_frame();
        add_random_frame();
        repeat (12) send_item(sas_pkg::ACT_TICK, noise());
      end

      start = sent_items;
      while (sent_items - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 20) begin
          // effect -> explosion -> jump to 0 never stops: runs to the chain cap
          clear_table();
          append_frame(sas_pkg::K_EFFECT, pick_duration(), 1'b0, 6'd0, 16'($urandom()),
                       16'($urandom()));
          append_frame(sas_pkg::K_EXPLOSION, pick_duration(), 1'b0, 6'd0, 16'($urandom()),
                       16'($urandom()));
          append_frame(sas_pkg::K_JUMP, pick_duration(), 1'b0, 6'd0, 16'($urandom()),
                       16'($urandom()));
          repeat (3) send_item(sas_pkg::ACT_TICK, noise());
        end else begin
          if ($urandom_range(0, 99) < 75) clear_table();
          repeat ($urandom_range(2, 8)) add_random_frame();
          steps = $urandom_range(4, 16);
          repeat (steps) begin
            r = $urandom_range(0, 99);
            if (r < 78)      send_item(sas_pkg::ACT_TICK, noise());
            else if (r < 84) send_item(sas_pkg::ACT_RESTART, noise());
            else if (r < 90) send_item(sas_pkg::ACT_SETFRZ, noise());
            else if (r < 94) add_random_frame();
            else if (r < 97)
              send_item(3'(sas_pkg::ACT_CLEAR + $urandom_range(1, 3)), noise());
            else             clear_table();
          end
        end
      end
      drain();
    end
    full_rate = 1'b0;

    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("sprite_animation_sequencer_tb passed");
    else
      $display("sprite_animation_sequencer_tb failed");
    $finish;
  end

endmodule
